FILE: rtl/crlf_at_pkg.sv
// shared types, codes and constants of the crlf line receiver
package crlf_at_pkg;

  localparam int unsigned BUF_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_REARM = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  // line status flags, as held by the control unit
  typedef struct packed {
    logic done;
    logic cr;
    logic power;
  } status_t;

endpackage

FILE: rtl/crlf_at_if.sv
// valid/ready channel interfaces for the input and result beats
interface crlf_at_in_if;
  import crlf_at_pkg::*;
  logic       valid;
  logic       ready;
  cmd_t       cmd;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, cmd, rx_byte, read_index, input ready);
  modport sink   (input valid, cmd, rx_byte, read_index, output ready);
endinterface

interface crlf_at_out_if;
  logic       valid;
  logic       ready;
  logic       line_done;
  logic       cr_pending;
  logic [7:0] byte_count;
  logic       power_on;
  logic [7:0] read_data;

  modport source (output valid, line_done, cr_pending, byte_count, power_on, read_data,
                  input ready);
  modport sink   (input valid, line_done, cr_pending, byte_count, power_on, read_data,
                  output ready);
endinterface

FILE: rtl/crlf_line_receiver_at_command.sv
// top level of the crlf line receiver with at power command
// Takes one beat per clock while ready: a received byte, a rearm or a line store read. Each
// input beat gives one result beat, registered, in the cycle after acceptance; a new beat is
// taken in the same cycle as the previous result leaves, so the sustained rate is one item per
// cycle while out_if.ready holds, set by the one-deep result register; the line store has
// separate read and write ports. The result shows the flags and byte count after the item, and
// for a read the stored byte (zero beyond the store depth). After reset the store is swept to
// zero, one entry a cycle, during which in_if.ready stays low. Bytes 0 to 3 of the store are
// mirrored in flip-flops so that the AT00 / AT01 check runs in the cycle of the line feed.
module crlf_line_receiver_at_command import crlf_at_pkg::*; #(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  crlf_at_in_if.sink   in_if,
  crlf_at_out_if.source out_if
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);

  logic          accept;
  logic          clr_busy;
  logic          out_valid_r, out_valid_nxt;
  logic          rd_hit_r, rd_hit_nxt;
  logic          rd_en;
  logic          idx_in_range;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  status_t       status;
  logic [AW-1:0] count;

  // one-deep result stage: refill in the cycle it drains
  assign in_if.ready = !clr_busy && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;

  assign idx_in_range = (32'(in_if.read_index) < 32'(BUF_DEPTH));
  assign rd_en        = accept && (in_if.cmd == CMD_READ) && idx_in_range;

  always_comb begin
    out_valid_nxt = out_valid_r;
    rd_hit_nxt    = rd_hit_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      rd_hit_nxt    = rd_en;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_hit_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rd_hit_r    <= rd_hit_nxt;
    end
  end

  crlf_at_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cmd     (in_if.cmd),
    .rx_byte (in_if.rx_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .status  (status),
    .count   (count)
  );

  crlf_at_store #(.BUF_DEPTH(BUF_DEPTH)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (AW'(in_if.read_index)),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  // status registers change only on acceptance, so they already hold the post-item state
  assign out_if.valid      = out_valid_r;
  assign out_if.line_done  = status.done;
  assign out_if.cr_pending = status.cr;
  assign out_if.byte_count = 8'(count);
  assign out_if.power_on   = status.power;
  assign out_if.read_data  = rd_hit_r ? rd_data : 8'h00;

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_if.ready)
    else $error("beat taken during store sweep");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat gave no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !accept)
    else $error("result overwritten while stalled");

endmodule

FILE: rtl/crlf_at_store.sv
// line store memory with a clearing sweep after reset
module crlf_at_store import crlf_at_pkg::*; #(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF,
  localparam int unsigned AW = $clog2(BUF_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic          clr_busy
);

  logic [7:0]    mem [BUF_DEPTH];
  logic [7:0]    rd_data_r;
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(BUF_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // sweep owns the write port while busy
  assign we    = clr_busy_r || wr_en;
  assign waddr = clr_busy_r ? clr_addr_r : wr_addr;
  assign wdata = clr_busy_r ? 8'h00 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

FILE: rtl/crlf_at_ctrl.sv
// line status flags, byte count, command bytes and the at power decode
module crlf_at_ctrl import crlf_at_pkg::*; #(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF,
  localparam int unsigned AW = $clog2(BUF_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  cmd_t          cmd,
  input  logic [7:0]    rx_byte,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output status_t       status,
  output logic [AW-1:0] count
);

  status_t       st_r, st_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic [7:0]    head_r [4];
  logic [7:0]    head_nxt [4];
  logic          is_head;
  logic          at_match;
  logic          power_nxt;

  assign is_head = (count_r[AW-1:2] == '0);

  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_data   = rx_byte;
    if (accept) begin
      case (cmd)
        CMD_BYTE: begin
          if (!st_r.done) begin
            if (st_r.cr) begin
              if (rx_byte != CHAR_LF) begin
                st_nxt.cr = 1'b0;
                count_nxt = '0;
              end else begin
                st_nxt.done = 1'b1;
                wr_en       = 1'b1;
              end
            end else if (rx_byte == CHAR_CR) begin
              st_nxt.cr = 1'b1;
            end else begin
              wr_en = 1'b1;
              // store full drops the line
              if (count_r == AW'(BUF_DEPTH - 1)) begin
                count_nxt = '0;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
          end
        end
        CMD_REARM: begin
          st_nxt.done = 1'b0;
          st_nxt.cr   = 1'b0;
          count_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_addr = count_r;

  // mirror of store bytes 0 to 3 with this beat's write applied
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      head_nxt[i] = head_r[i];
    end
    if (wr_en && is_head) begin
      head_nxt[count_r[1:0]] = wr_data;
    end
  end

  assign at_match = (head_nxt[0] == CHAR_A) && (head_nxt[1] == CHAR_T) &&
                    (head_nxt[2] == CHAR_ZERO);

  // power decode only on the terminating line feed
  always_comb begin
    power_nxt = st_r.power;
    if (st_nxt.done && !st_r.done && at_match) begin
      if (head_nxt[3] == CHAR_ZERO) begin
        power_nxt = 1'b1;
      end else if (head_nxt[3] == CHAR_ONE) begin
        power_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      count_r <= '0;
      for (int i = 0; i < 4; i++) begin
        head_r[i] <= 8'h00;
      end
    end else begin
      st_r.done  <= st_nxt.done;
      st_r.cr    <= st_nxt.cr;
      st_r.power <= power_nxt;
      count_r    <= count_nxt;
      for (int i = 0; i < 4; i++) begin
        head_r[i] <= head_nxt[i];
      end
    end
  end

  assign status = st_r;
  assign count  = count_r;

  a_done_keeps_cr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.done |-> st_r.cr)
    else $error("line done without cr flag");

  a_count_frozen_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.done && !(accept && cmd == CMD_REARM)) |=> $stable(count_r))
    else $error("count moved while line held");

  a_no_write_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.done |-> !wr_en)
    else $error("store written while line held");

endmodule
